/* rtl/base64_stream_codec_macros.svh */
// ----------------------------------------------------------------------------
// base64_stream_codec_macros
// Assertion macros used by the codec's checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// same-cycle implication
`define B64SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B64SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/b64sc_pkg.sv */
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types and character helpers for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       out_last;
    } out_t;

    // one item's worth of results, oldest byte in the top bits
    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  left;
        logic        has_data;
        logic        last;
    } grp_t;

    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        begin
            if (s < 6'd26)
                c = 8'h41 + {2'b00, s};
            else if (s < 6'd52)
                c = 8'h47 + {2'b00, s};
            else if (s < 6'd62)
                c = 8'hFC + {2'b00, s};
            else if (s == 6'd62)
                c = 8'h2B;
            else
                c = 8'h2F;
            return c;
        end
    endfunction

    // {valid, sextet}
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [6:0] r;
        begin
            case (c) inside
                [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
                [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h47)};
                [8'h30:8'h39]: r = {1'b1, 6'(c + 8'h04)};
                8'h2B:         r = {1'b1, 6'd62};
                8'h2F:         r = {1'b1, 6'd63};
                default:       r = 7'h00;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/base64_stream_codec.sv */
// An item's first result is registered in the drain slot driving out, or waits in the pending slot.
// Throughput: one input request per cycle until a finished group waits behind the
//   one draining; results drain one per ready cycle from a two-deep group buffer.
// Ready receiver: encode input backs up while groups drain; decode sustains one character per cycle.
// Reset: async active low; mode returns to encode and the open group is cleared.
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder, one byte per request, with last flush.
// ----------------------------------------------------------------------------
module base64_stream_codec (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  b64sc_pkg::in_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output b64sc_pkg::out_t  out_data
);
    import b64sc_pkg::*;

    logic        mode_reg;
    logic [23:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stop_reg, stop_next;

    grp_t        grp;
    logic        emit;
    grp_t        pend_reg;
    logic        pend_valid_reg, pend_valid_next;
    grp_t        drn_reg;
    logic        drn_valid_reg;

    logic [23:0] enc_buf;
    logic [23:0] enc_v;
    logic [6:0]  sx;
    logic        take;
    logic [23:0] dbuf;
    logic [2:0]  cnt_after;

    logic        acc;
    logic        out_take;
    logic        finishing;
    logic        drain_free;
    logic        pend_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = !pend_valid_reg;
    assign acc       = in_valid && in_ready;

    always_comb
    begin
        grp          = '0;
        grp.has_data = 1'b1;
        grp.last     = in_data.in_last;
        emit         = 1'b0;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        stop_next    = stop_reg;
        enc_buf      = {buf_reg[15:0], in_data.in_byte};
        enc_v        = '0;
        sx           = dec_sextet(in_data.in_byte);
        take         = 1'b0;
        dbuf         = buf_reg;
        cnt_after    = {1'b0, cnt_reg};

        if (mode_reg == MODE_ENCODE)
        begin
            if (cnt_reg == 2'd2)
            begin
                grp.data = {enc_char(enc_buf[23:18]), enc_char(enc_buf[17:12]),
                            enc_char(enc_buf[11:6]),  enc_char(enc_buf[5:0])};
                grp.left = 2'd3;
                emit     = 1'b1;
                buf_next = '0;
                cnt_next = '0;
            end
            else
            begin
                buf_next = enc_buf;
                cnt_next = cnt_reg + 2'd1;
                if (in_data.in_last)
                begin
                    enc_v    = (cnt_reg == 2'd0) ? {in_data.in_byte, 16'h0000}
                                                 : {enc_buf[15:0], 8'h00};
                    grp.data = {enc_char(enc_v[23:18]), enc_char(enc_v[17:12]),
                                (cnt_reg == 2'd1) ? enc_char(enc_v[11:6]) : PAD_CHAR,
                                PAD_CHAR};
                    grp.left = 2'd3;
                    emit     = 1'b1;
                end
            end
        end
        else
        begin
            take = !stop_reg && sx[6];
            if (!stop_reg && !sx[6])
                stop_next = 1'b1;
            if (take)
            begin
                dbuf      = {buf_reg[17:0], sx[5:0]};
                cnt_after = {1'b0, cnt_reg} + 3'd1;
            end
            if (cnt_after == 3'd4)
            begin
                grp.data = {dbuf, 8'h00};
                grp.left = 2'd2;
                emit     = 1'b1;
                buf_next = '0;
                cnt_next = '0;
            end
            else
            begin
                buf_next = dbuf;
                cnt_next = cnt_after[1:0];
                if (in_data.in_last)
                begin
                    emit = 1'b1;
                    case (cnt_after[1:0])
                        2'd2:
                        begin
                            grp.data = {dbuf[11:4], 24'h000000};
                            grp.left = 2'd0;
                        end
                        2'd3:
                        begin
                            grp.data = {dbuf[17:2], 16'h0000};
                            grp.left = 2'd1;
                        end
                        default:
                        begin
                            grp.data     = '0;
                            grp.left     = 2'd0;
                            grp.has_data = 1'b0;
                        end
                    endcase
                end
            end
        end

        if (in_data.in_last)
        begin
            buf_next  = '0;
            cnt_next  = '0;
            stop_next = 1'b0;
        end
    end

    assign out_valid         = drn_valid_reg;
    assign out_data.out_byte = drn_reg.data[31:24];
    assign out_data.has_data = drn_reg.has_data;
    assign out_data.out_last = drn_reg.last && (drn_reg.left == 2'd0);

    assign out_take   = out_valid && out_ready;
    assign finishing  = out_take && (drn_reg.left == 2'd0);
    assign drain_free = !drn_valid_reg || finishing;
    assign pend_load  = acc && emit && (!drain_free || pend_valid_reg);

    always_comb
    begin
        pend_valid_next = pend_load || (pend_valid_reg && !drain_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENCODE;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            stop_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            drn_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
                buf_reg  <= '0;
                cnt_reg  <= '0;
                stop_reg <= 1'b0;
            end
            else if (acc)
            begin
                buf_reg  <= buf_next;
                cnt_reg  <= cnt_next;
                stop_reg <= stop_next;
            end
            pend_valid_reg <= pend_valid_next;
            if (drain_free)
                drn_valid_reg <= pend_valid_reg || (acc && emit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
            pend_reg <= grp;
        if (drain_free)
        begin
            if (pend_valid_reg)
                drn_reg <= pend_reg;
            else
                drn_reg <= grp;
        end
        else if (out_take)
        begin
            drn_reg.data <= {drn_reg.data[23:0], 8'h00};
            drn_reg.left <= drn_reg.left - 2'd1;
        end
    end

endmodule

/* rtl/b64sc_checker.sv */
// ----------------------------------------------------------------------------
// b64sc_checker
// Port-level checks for the base64 stream codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_macros.svh"

module b64sc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input b64sc_pkg::out_t  out_data
);
    import b64sc_pkg::*;

    // a held result stays put
    `B64SC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // an empty marker is always the zero end of a message
    `B64SC_ASSERT_NOW(a_empty_end, clk, rst_n, out_valid && !out_data.has_data, out_data.out_last && (out_data.out_byte == 8'h00), "empty marker not a zero end")

    // input only backs up behind owed results
    `B64SC_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid, "input stalled with no result pending")

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (.*);

/* tb/base64_stream_codec_tb.sv */
// ----------------------------------------------------------------------------
// base64_stream_codec_tb
// Drives byte requests through the codec in both modes. Each accepted request
// is run through a local base64 predictor, and every output request is
// compared field by field against the oldest predicted result. Sender bursts,
// receiver stalls and a long receiver hold-off exercise flow control.
// ----------------------------------------------------------------------------
module base64_stream_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64sc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // predictor state
    logic        pm_mode;
    logic [23:0] pm_buf;
    int          pm_cnt;
    bit          pm_stop;
    int          items_used;

    out_t        pending_out[$];
    logic [7:0]  msg_bytes[$];
    int          mismatch_count;
    int          burst_left;
    int          hold_req;
    int          idle_cycles;

    base64_stream_codec uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] b64_char(input int s);
        if (s < 26)
            return 8'("A" + s);
        else if (s < 52)
            return 8'("a" + s - 26);
        else if (s < 62)
            return 8'("0" + s - 52);
        else if (s == 62)
            return "+";
        else
            return "/";
    endfunction

    // 64 marks a stop character
    function automatic int b64_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c - "A");
        else if (c >= "a" && c <= "z")
            return int'(c - "a") + 26;
        else if (c >= "0" && c <= "9")
            return int'(c - "0") + 52;
        else if (c == "+")
            return 62;
        else if (c == "/")
            return 63;
        else
            return 64;
    endfunction

    function automatic void clear_group();
        pm_buf  = '0;
        pm_cnt  = 0;
        pm_stop = 1'b0;
    endfunction

    function automatic void predict_codec(input in_t it);
        out_t        res[4];
        int          n;
        int          k;
        int          s;
        logic [23:0] v;
        n = 0;
        if (!(pm_mode == MODE_DECODE && pm_stop && !it.in_last))
            items_used++;
        if (pm_mode == MODE_ENCODE) begin
            pm_buf = {pm_buf[15:0], it.in_byte};
            pm_cnt++;
            if (pm_cnt == 3) begin
                for (k = 0; k < 4; k++) begin
                    res[n] = '{b64_char(pm_buf[23 - 6 * k -: 6]), 1'b1, 1'b0};
                    n++;
                end
                pm_cnt = 0;
                pm_buf = '0;
            end else if (it.in_last) begin
                v = pm_buf << (8 * (3 - pm_cnt));
                for (k = 0; k < 4; k++) begin
                    res[n] = '{(k <= pm_cnt) ? b64_char(v[23 - 6 * k -: 6]) : PAD_CHAR,
                               1'b1, 1'b0};
                    n++;
                end
            end
        end else begin
            if (!pm_stop) begin
                s = b64_sextet(it.in_byte);
                if (s > 63) begin
                    pm_stop = 1'b1;
                end else begin
                    pm_buf = {pm_buf[17:0], 6'(s)};
                    pm_cnt++;
                    if (pm_cnt == 4) begin
                        for (k = 0; k < 3; k++) begin
                            res[n] = '{pm_buf[23 - 8 * k -: 8], 1'b1, 1'b0};
                            n++;
                        end
                        pm_cnt = 0;
                        pm_buf = '0;
                    end
                end
            end
            if (it.in_last && pm_cnt > 0) begin
                v = pm_buf << (6 * (4 - pm_cnt));
                for (k = 0; k < pm_cnt - 1; k++) begin
                    res[n] = '{v[23 - 8 * k -: 8], 1'b1, 1'b0};
                    n++;
                end
            end
            if (it.in_last && n == 0) begin
                res[n] = '{8'h00, 1'b0, 1'b0};
                n++;
            end
        end
        if (it.in_last) begin
            res[n - 1].out_last = 1'b1;
            clear_group();
        end
        for (k = 0; k < n; k++)
            pending_out = {pending_out, res[k]};
    endfunction

    task automatic send_req(input logic [7:0] b, input logic l);
        int  gap;
        in_t item;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item.in_byte = b;
        item.in_last = l;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        predict_codec(item);
    endtask

    task automatic send_msg();
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_req(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    task automatic load_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            msg_bytes = {msg_bytes, txt[i]};
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pm_mode = m;
        clear_group();
        @(posedge clk);
    endtask

    task automatic test_encode_groups();
        set_mode(MODE_ENCODE);
        load_text("Man");
        send_msg();
        msg_bytes = {8'h00};
        send_msg();
        msg_bytes = {8'hFF, 8'hFF};
        send_msg();
        msg_bytes = {8'hFF, 8'h00, 8'h80, 8'h01};
        send_msg();
        settle();
    endtask

    task automatic test_decode_groups();
        set_mode(MODE_DECODE);
        load_text("TW0u+/9z");
        send_msg();
        load_text("QQ==");
        send_msg();
        // one leftover character flushes no data, only an empty end marker
        load_text("A");
        send_msg();
        msg_bytes = {8'hFF, 8'h41};
        send_msg();
        load_text("Zg");
        msg_bytes = {msg_bytes, 8'h80};
        load_text("A");
        send_msg();
        settle();
    endtask

    task automatic test_mode_switch();
        set_mode(MODE_ENCODE);
        send_req(8'h41, 1'b0);
        send_req(8'h42, 1'b0);
        settle();
        set_mode(MODE_ENCODE);
        send_req(8'h43, 1'b1);
        settle();
        set_mode(MODE_DECODE);
        send_req("T", 1'b0);
        send_req("W", 1'b0);
        settle();
        set_mode(MODE_DECODE);
        load_text("QQ");
        send_msg();
        settle();
    endtask

    task automatic test_backpressure();
        int i;
        set_mode(MODE_ENCODE);
        hold_req = HOLD_CYCLES;
        for (i = 0; i < 48; i++)
            msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
        send_msg();
        settle();
    endtask

    task automatic test_random_messages();
        int         start;
        int         phase;
        int         phase_end;
        int         len;
        int         kind;
        int         i;
        int         pads;
        logic [7:0] c;
        start = items_used;
        phase = 0;
        while (items_used - start < RANDOM_ITEMS) begin
            settle();
            set_mode((phase % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
            phase_end = items_used + $urandom_range(40, 90);
            while (items_used < phase_end) begin
                if (pm_mode == MODE_ENCODE) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                      : $urandom_range(1, 8);
                    for (i = 0; i < len; i++)
                        msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
                end else begin
                    kind = $urandom_range(0, 9);
                    if (kind <= 5) begin
                        len = 4 * $urandom_range(1, 4);
                        for (i = 0; i < len; i++)
                            msg_bytes = {msg_bytes, b64_char($urandom_range(0, 63))};
                        pads = $urandom_range(0, 2);
                        for (i = 0; i < pads; i++)
                            msg_bytes[len - 1 - i] = PAD_CHAR;
                    end else if (kind == 6) begin
                        len = $urandom_range(1, 15);
                        for (i = 0; i < len; i++)
                            msg_bytes = {msg_bytes, b64_char($urandom_range(0, 63))};
                    end else if (kind == 7) begin
                        len = $urandom_range(1, 8);
                        for (i = 0; i < len; i++)
                            msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
                    end else if (kind == 8) begin
                        len = $urandom_range(2, 12);
                        for (i = 0; i < len; i++)
                            msg_bytes = {msg_bytes, b64_char($urandom_range(0, 63))};
                        do c = 8'($urandom_range(0, 255)); while (b64_sextet(c) < 64);
                        msg_bytes[$urandom_range(0, len - 1)] = c;
                    end else begin
                        msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
                    end
                end
                send_msg();
            end
            phase++;
        end
        settle();
    endtask

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        int         rx_style;
        int         rx_left;
        int         rx_phase;
        logic [7:0] rx_pat;
        rx_style  = 0;
        rx_left   = 0;
        rx_phase  = 0;
        rx_pat    = 8'hFF;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req > 0) begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end else begin
                if (rx_left == 0) begin
                    rx_style = $urandom_range(0, 3);
                    rx_left  = $urandom_range(16, 96);
                    rx_pat   = 8'($urandom) | 8'h01;
                end
                rx_left--;
                rx_phase++;
                case (rx_style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= rx_pat[rx_phase % 8];
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : check_out
        out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_out.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got byte %h data %b last %b",
                         $time, out_data.out_byte, out_data.has_data, out_data.out_last);
            end else begin
                want = pending_out.pop_front();
                if (out_data.out_byte !== want.out_byte ||
                    out_data.has_data !== want.has_data ||
                    out_data.out_last !== want.out_last) begin
                    mismatch_count++;
                    $display("%0t: expected byte %h data %b last %b, got byte %h data %b last %b",
                             $time, want.out_byte, want.has_data, want.out_last,
                             out_data.out_byte, out_data.has_data, out_data.out_last);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        hold_req       = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        items_used     = 0;
        pm_mode        = MODE_ENCODE;
        clear_group();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_groups();
        test_decode_groups();
        test_mode_switch();
        test_backpressure();
        test_random_messages();
        settle();
        if (mismatch_count == 0 && pending_out.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/b64sc_pkg.sv
rtl/base64_stream_codec.sv
rtl/b64sc_checker.sv
tb/base64_stream_codec_tb.sv
